[sv/kvsa_pkg.sv]
// shared constants and types for the kv slot allocator
package kvsa_pkg;

  localparam int LAYERS      = 2;
  localparam int ROW_COUNT   = 64;
  localparam int SLOT_COUNT  = 16384;
  localparam int MAX_LEN     = 1024;

  localparam int LAYER_W   = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int SLOT_W    = 14;
  localparam int SIDX_W    = $clog2(SLOT_COUNT);
  localparam int COUNT_W   = SIDX_W + 1;
  localparam int LEN_W     = 16;
  localparam int LIDX_W    = $clog2(MAX_LEN);
  localparam int BSZ_W     = 7;
  localparam int BIX_W     = 6;
  localparam int TOKEN_W   = 32;
  localparam int POS_W     = 31;

  localparam int STACK_DEPTH = LAYERS * SLOT_COUNT;
  localparam int LROWS       = LAYERS * ROW_COUNT;
  localparam int TABLE_DEPTH = LAYERS * ROW_COUNT * MAX_LEN;

  localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_OK       = 1'b0,
    ST_NO_SLOTS = 1'b1
  } status_t;

endpackage

[sv/kv_slot_allocate_and_map.sv]
// kv cache slot allocator: free-slot stacks, row lengths and slot tables per layer
// In each transaction the accept edge issues the reads of the row length
// and the free-stack entry from their single-port memories; the update cycle, held while
// the output is stalled, updates the count, writes the length, slot table and stack back
// and loads the output register. A new transaction is accepted only once the update
// cycle has retired, so transactions never overlap. Row lengths reset to zero
// through per-row valid bits; no clearing pass is needed after reset.
module kv_slot_allocate_and_map (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    command,
  input  logic [kvsa_pkg::LAYER_W-1:0]  layer,
  input  logic [kvsa_pkg::ROW_W-1:0]    row,
  input  logic [kvsa_pkg::TOKEN_W-1:0]  token,
  input  logic [kvsa_pkg::POS_W-1:0]    position,
  input  logic [kvsa_pkg::BSZ_W-1:0]    batch_count,
  input  logic [kvsa_pkg::BIX_W-1:0]    batch_index,
  input  logic [kvsa_pkg::SLOT_W-1:0]   slot_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kvsa_pkg::TOKEN_W-1:0]  token_out,
  output logic [kvsa_pkg::POS_W-1:0]    position_out,
  output logic [kvsa_pkg::LAYER_W-1:0]  layer_out,
  output logic [kvsa_pkg::ROW_W-1:0]    row_out,
  output logic [kvsa_pkg::LEN_W-1:0]    context_len,
  output logic [kvsa_pkg::SLOT_W-1:0]   slot_out,
  output logic                          status
);
  import kvsa_pkg::*;

  localparam int SADDR_W = LAYER_W + SIDX_W;
  localparam int RADDR_W = LAYER_W + ROW_W;
  localparam int TADDR_W = RADDR_W + LIDX_W;

  // memories
  logic [SLOT_W-1:0] free_stack [STACK_DEPTH];
  logic [LEN_W-1:0]  row_length [LROWS];
  logic [SLOT_W-1:0] slot_table [TABLE_DEPTH];

  logic [LROWS-1:0]   row_valid;
  logic [COUNT_W-1:0] free_count [LAYERS];

  // execute stage
  logic               exec_valid;
  cmd_t               x_cmd;
  logic [LAYER_W-1:0] x_layer;
  logic [ROW_W-1:0]   x_row;
  logic [TOKEN_W-1:0] x_token;
  logic [POS_W-1:0]   x_position;
  logic [BSZ_W-1:0]   x_bsz;
  logic [SLOT_W-1:0]  x_slot_value;
  logic               x_dec_ok;
  logic               x_last;
  logic               x_len_valid;
  logic [SLOT_W-1:0]  stack_rdata;
  logic [LEN_W-1:0]   len_rdata;

  logic               in_accept;
  logic               exec_done;
  logic [COUNT_W-1:0] in_cnt;
  logic [COUNT_W:0]   sp_wide;
  logic               dec_ok;
  logic [SADDR_W-1:0] stack_raddr;
  logic [RADDR_W-1:0] in_raddr;

  logic [COUNT_W-1:0] x_cnt;
  logic [COUNT_W-1:0] cnt_next;
  logic               cnt_we;
  logic [LEN_W-1:0]   ctx;
  logic [LEN_W-1:0]   ctx_res;
  logic [SLOT_W-1:0]  slot_res;
  logic               status_res;
  logic               stack_we;
  logic [SADDR_W-1:0] stack_waddr;
  logic               len_we;
  logic [LEN_W-1:0]   len_wdata;
  logic               valid_set;
  logic               valid_clr;
  logic               table_we;
  logic [RADDR_W-1:0] x_raddr;
  logic [TADDR_W-1:0] table_waddr;

  assign in_stall  = exec_valid;
  assign in_accept = in_valid && !in_stall;
  assign exec_done = exec_valid && (!out_valid || !out_stall);

  // read addresses are formed from the inputs and the current counts at accept
  always_comb begin
    in_cnt  = free_count[layer];
    sp_wide = {1'b0, in_cnt} - (COUNT_W+1)'(batch_count) + (COUNT_W+1)'(batch_index);
    dec_ok  = (batch_count != '0) && ({1'b0, batch_index} < batch_count) &&
              (in_cnt >= COUNT_W'(batch_count));
    stack_raddr = {layer, sp_wide[SIDX_W-1:0]};
    in_raddr    = {layer, row};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exec_valid <= 1'b0;
    end else if (in_accept) begin
      exec_valid <= 1'b1;
    end else if (exec_done) begin
      exec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_cmd        <= cmd_t'(command);
      x_layer      <= layer;
      x_row        <= row;
      x_token      <= token;
      x_position   <= position;
      x_bsz        <= batch_count;
      x_slot_value <= slot_value;
      x_dec_ok     <= dec_ok;
      x_last       <= ({1'b0, batch_index} == (batch_count - BSZ_W'(1)));
      x_len_valid  <= row_valid[in_raddr];
    end
  end

  // update cycle
  always_comb begin
    x_raddr     = {x_layer, x_row};
    x_cnt       = free_count[x_layer];
    ctx         = x_len_valid ? len_rdata : '0;
    ctx_res     = ctx;
    slot_res    = '0;
    status_res  = ST_OK;
    cnt_we      = 1'b0;
    cnt_next    = x_cnt;
    stack_we    = 1'b0;
    stack_waddr = {x_layer, x_cnt[SIDX_W-1:0]};
    len_we      = 1'b0;
    len_wdata   = ctx + LEN_W'(1);
    valid_set   = 1'b0;
    valid_clr   = 1'b0;
    table_we    = 1'b0;
    table_waddr = {x_raddr, ctx[LIDX_W-1:0]};
    case (x_cmd)
      CMD_PUSH: begin
        if (x_cnt < COUNT_W'(SLOT_COUNT)) begin
          stack_we = 1'b1;
          cnt_we   = 1'b1;
          cnt_next = x_cnt + COUNT_W'(1);
        end
      end
      CMD_DECODE: begin
        if (x_dec_ok) begin
          slot_res = stack_rdata;
          table_we = (ctx < LEN_W'(MAX_LEN));
          if (ctx != LEN_SAT) begin
            len_we    = 1'b1;
            valid_set = 1'b1;
          end
          if (x_last) begin
            cnt_we   = 1'b1;
            cnt_next = x_cnt - COUNT_W'(x_bsz);
          end
        end else begin
          status_res = ST_NO_SLOTS;
          ctx_res    = '0;
        end
      end
      CMD_CLEAR: begin
        // an invalid row reads back as zero
        valid_clr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (exec_done && stack_we) begin
      free_stack[stack_waddr] <= x_slot_value;
    end
    if (in_accept) begin
      stack_rdata <= free_stack[stack_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done && len_we) begin
      row_length[x_raddr] <= len_wdata;
    end
    if (in_accept) begin
      len_rdata <= row_length[in_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done && table_we) begin
      slot_table[table_waddr] <= stack_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (exec_done) begin
      if (valid_set) begin
        row_valid[x_raddr] <= 1'b1;
      end else if (valid_clr) begin
        row_valid[x_raddr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAYERS; i++) begin
        free_count[i] <= '0;
      end
    end else if (exec_done && cnt_we) begin
      free_count[x_layer] <= cnt_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      token_out    <= x_token;
      position_out <= x_position;
      layer_out    <= x_layer;
      row_out      <= x_row;
      context_len  <= ctx_res;
      slot_out     <= slot_res;
      status       <= status_res;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> exec_valid)
    else $error("accepted transaction did not enter the update cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    exec_valid |-> free_count[x_layer] <= COUNT_W'(SLOT_COUNT))
    else $error("free count above total slots");

  a_fail_zeroes: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> context_len == '0 && slot_out == '0)
    else $error("failed decode carries nonzero length or slot");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    exec_valid && !exec_done |=> exec_valid && $stable(x_token))
    else $error("update cycle lost while output is stalled");

endmodule
